[rtl/ppu_pkg.sv]
`default_nettype none

package ppu_pkg;

   // Bus access kinds
   typedef enum logic [1:0] {
      FUNC_WRITE  = 2'd0,
      FUNC_READ   = 2'd1,
      FUNC_STATUS = 2'd2,
      FUNC_NONE   = 2'd3
   } func_type;

   // Register numbers inside the eight-register window
   localparam logic [2:0] REG_CTRL0   = 3'd0;
   localparam logic [2:0] REG_CTRL1   = 3'd1;
   localparam logic [2:0] REG_STATUS  = 3'd2;
   localparam logic [2:0] REG_SPR_ADR = 3'd3;
   localparam logic [2:0] REG_SPR_DAT = 3'd4;
   localparam logic [2:0] REG_SCROLL  = 3'd5;
   localparam logic [2:0] REG_ADDRESS = 3'd6;
   localparam logic [2:0] REG_DATA    = 3'd7;

   // Video address step select and steps
   localparam int unsigned STEP_BIT   = 2;
   localparam logic [15:0] STEP_ROW   = 16'h0020;
   localparam logic [15:0] STEP_ONE   = 16'h0001;

   // Status bits that survive a status read
   localparam logic [7:0]  STATUS_KEEP = 8'h1F;

   // Video memory geometry: 16K bytes, with the 0x2000-0x2EFF window
   // also reachable through writes at 0x3000-0x3EFF
   localparam int unsigned VADDR_W    = 14;
   localparam int unsigned MIRROR_W   = 12;
   localparam logic [VADDR_W-1:0] NT_LO     = 14'h2000;
   localparam logic [VADDR_W-1:0] NT_HI     = 14'h2EFF;
   localparam logic [VADDR_W-1:0] MIRROR_LO = 14'h3000;
   localparam logic [VADDR_W-1:0] MIRROR_HI = 14'h3EFF;

   // Video memory access from the register logic
   typedef struct packed {
      logic               wr_en;
      logic               rd_en;
      logic [VADDR_W-1:0] addr;
      logic [7:0]         wdata;
   } vram_req_type;

   // One result item
   typedef struct packed {
      logic [7:0]  read_data;
      logic [15:0] current_address;
      logic [14:0] temp_address;
      logic [2:0]  fine_scroll_x;
      logic [7:0]  control0;
      logic [7:0]  control1;
   } result_type;

endpackage

`default_nettype wire

[rtl/ppu_req_if.sv]
`default_nettype none

interface ppu_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] func;
   logic [2:0] reg_index;
   logic [7:0] write_data;

   modport source (output valid, func, reg_index, write_data, input ready);
   modport sink   (input valid, func, reg_index, write_data, output ready);
endinterface

`default_nettype wire

[rtl/ppu_rsp_if.sv]
`default_nettype none

interface ppu_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  read_data;
   logic [15:0] current_address;
   logic [14:0] temp_address;
   logic [2:0]  fine_scroll_x;
   logic [7:0]  control0;
   logic [7:0]  control1;

   modport source (output valid, read_data, current_address, temp_address,
                   fine_scroll_x, control0, control1, input ready);
   modport sink   (input valid, read_data, current_address, temp_address,
                   fine_scroll_x, control0, control1, output ready);
endinterface

`default_nettype wire

[rtl/ppu_cpu_register_port.sv]
// Results are registered. Throughput: one request per cycle while the skid
// entry is free; the register update and result are a single pass of
// logic, and the data-port read buffer fills from a registered video
// memory read the cycle after the access.
// Reset (synchronous, active high) clears all registers, toggles, the read
// buffer and the result stage; video memory is not cleared.
`default_nettype none

module ppu_cpu_register_port (
   input  wire logic clock,
   input  wire logic reset,
   ppu_req_if.sink   req_bus,
   ppu_rsp_if.source rsp_bus
);

   logic                  req_transfer;
   ppu_pkg::vram_req_type vram_req;
   ppu_pkg::result_type   result;
   ppu_pkg::result_type   rsp_data;
   logic [7:0]            buffer_data;

   assign req_transfer = req_bus.valid & req_bus.ready;

   ppu_regs u_regs (
      .clock       (clock),
      .reset       (reset),
      .accept      (req_transfer),
      .func        (req_bus.func),
      .reg_index   (req_bus.reg_index),
      .write_data  (req_bus.write_data),
      .buffer_data (buffer_data),
      .vram_req    (vram_req),
      .result      (result)
   );

   ppu_vram u_vram (
      .clock       (clock),
      .reset       (reset),
      .vram_req    (vram_req),
      .buffer_data (buffer_data)
   );

   ppu_rsp_skid u_skid (
      .clock       (clock),
      .reset       (reset),
      .in_transfer (req_transfer),
      .in_data     (result),
      .in_ready    (req_bus.ready),
      .out_valid   (rsp_bus.valid),
      .out_ready   (rsp_bus.ready),
      .out_data    (rsp_data)
   );

   // Result fields onto the channel
   assign rsp_bus.read_data       = rsp_data.read_data;
   assign rsp_bus.current_address = rsp_data.current_address;
   assign rsp_bus.temp_address    = rsp_data.temp_address;
   assign rsp_bus.fine_scroll_x   = rsp_data.fine_scroll_x;
   assign rsp_bus.control0        = rsp_data.control0;
   assign rsp_bus.control1        = rsp_data.control1;

   // Every request transfer leaves a result waiting
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      req_transfer |=> rsp_bus.valid)
      else $error("request transfer without a result");

   // Skid entry in use only behind a held result
   a_skid_behind_result: assert property (@(posedge clock) disable iff (reset)
      !req_bus.ready |-> rsp_bus.valid)
      else $error("skid entry full while result stage empty");

   // Input stalls only after a result was held back
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      $fell(req_bus.ready) |-> $past(rsp_bus.valid && !rsp_bus.ready))
      else $error("request side stalled without a held result");

endmodule

`default_nettype wire

[rtl/ppu_vram.sv]
`default_nettype none

// Video memory with the data-port read buffer.
// The main array holds every address; a second array holds the
// 0x2000-0x2EFF window, which also takes writes made at 0x3000-0x3EFF.
module ppu_vram (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire ppu_pkg::vram_req_type vram_req,
   output logic [7:0]                 buffer_data
);

   localparam int unsigned MAIN_DEPTH   = 1 << ppu_pkg::VADDR_W;
   localparam int unsigned MIRROR_DEPTH = 1 << ppu_pkg::MIRROR_W;

   logic [7:0] main_mem   [MAIN_DEPTH];
   logic [7:0] mirror_mem [MIRROR_DEPTH];

   logic [7:0] main_q_ff;
   logic [7:0] mirror_q_ff;
   logic       sel_mirror_ff;
   logic       pending_ff;
   logic       pending_in;
   logic [7:0] buffer_ff;
   logic [7:0] buffer_in;

   logic [ppu_pkg::MIRROR_W-1:0] mirror_addr;
   logic in_nt;
   logic in_mirror;
   logic [7:0] fetched;

   // Address decode
   assign mirror_addr = vram_req.addr[ppu_pkg::MIRROR_W-1:0];
   assign in_nt       = (vram_req.addr >= ppu_pkg::NT_LO) && (vram_req.addr <= ppu_pkg::NT_HI);
   assign in_mirror   = (vram_req.addr >= ppu_pkg::MIRROR_LO) &&
                        (vram_req.addr <= ppu_pkg::MIRROR_HI);

   // Memory ports: one write and one registered read per array
   always_ff @(posedge clock) begin
      if (vram_req.wr_en) begin
         main_mem[vram_req.addr] <= vram_req.wdata;
      end
      if (vram_req.wr_en && (in_nt || in_mirror)) begin
         mirror_mem[mirror_addr] <= vram_req.wdata;
      end
      if (vram_req.rd_en) begin
         main_q_ff     <= main_mem[vram_req.addr];
         mirror_q_ff   <= mirror_mem[mirror_addr];
         sel_mirror_ff <= in_nt;
      end
   end

   // Read buffer: fetched data stands in for the buffer until folded in
   assign fetched     = sel_mirror_ff ? mirror_q_ff : main_q_ff;
   assign buffer_data = pending_ff ? fetched : buffer_ff;
   assign buffer_in   = buffer_data;
   assign pending_in  = vram_req.rd_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= 1'b0;
         buffer_ff  <= '0;
      end else begin
         pending_ff <= pending_in;
         buffer_ff  <= buffer_in;
      end
   end

endmodule

`default_nettype wire

[rtl/ppu_regs.sv]
`default_nettype none

// Register file of the port: control, status, scroll/address latches,
// toggles and video address. Works out the result of one transfer.
module ppu_regs (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  accept,
   input  wire logic [1:0]            func,
   input  wire logic [2:0]            reg_index,
   input  wire logic [7:0]            write_data,
   input  wire logic [7:0]            buffer_data,
   output ppu_pkg::vram_req_type      vram_req,
   output ppu_pkg::result_type        result
);

   logic [7:0]  ctrl0_ff,    ctrl0_in;
   logic [7:0]  ctrl1_ff,    ctrl1_in;
   logic [7:0]  status_ff,   status_in;
   logic [14:0] latch_ff,    latch_in;
   logic [15:0] vaddr_ff,    vaddr_in;
   logic [2:0]  fine_x_ff,   fine_x_in;
   logic        scroll_t_ff, scroll_t_in;
   logic        addr_t_ff,   addr_t_in;

   logic [15:0] step;
   logic [7:0]  rd_data;
   logic        is_write;
   logic        is_read;

   assign step     = ctrl0_ff[ppu_pkg::STEP_BIT] ? ppu_pkg::STEP_ROW : ppu_pkg::STEP_ONE;
   assign is_write = accept && (func == ppu_pkg::FUNC_WRITE);
   assign is_read  = accept && (func == ppu_pkg::FUNC_READ);

   // Next state for this transfer
   always_comb begin
      ctrl0_in    = ctrl0_ff;
      ctrl1_in    = ctrl1_ff;
      status_in   = status_ff;
      latch_in    = latch_ff;
      vaddr_in    = vaddr_ff;
      fine_x_in   = fine_x_ff;
      scroll_t_in = scroll_t_ff;
      addr_t_in   = addr_t_ff;
      rd_data     = '0;
      vram_req    = '{wr_en: 1'b0, rd_en: 1'b0,
                      addr: vaddr_ff[ppu_pkg::VADDR_W-1:0], wdata: write_data};

      if (is_write) begin
         case (reg_index)
            ppu_pkg::REG_CTRL0: begin
               ctrl0_in        = write_data;
               latch_in[11:10] = write_data[1:0];
            end
            ppu_pkg::REG_CTRL1: begin
               ctrl1_in = write_data;
            end
            ppu_pkg::REG_SCROLL: begin
               if (scroll_t_ff) begin
                  latch_in = {write_data[2:0], latch_ff[11:10], write_data[7:3],
                              latch_ff[4:0]};
               end else begin
                  latch_in[4:0] = write_data[7:3];
                  fine_x_in     = write_data[2:0];
               end
               scroll_t_in = ~scroll_t_ff;
            end
            ppu_pkg::REG_ADDRESS: begin
               if (addr_t_ff) begin
                  latch_in = {latch_ff[14:8], write_data};
                  vaddr_in = {1'b0, latch_ff[14:8], write_data};
               end else begin
                  latch_in = {1'b0, write_data[5:0], latch_ff[7:0]};
               end
               addr_t_in = ~addr_t_ff;
            end
            ppu_pkg::REG_DATA: begin
               vram_req.wr_en = 1'b1;
               vaddr_in       = vaddr_ff + step;
            end
            default: begin
               // status is read-only; sprite address and data have no
               // read path on this port
            end
         endcase
      end else if (is_read) begin
         case (reg_index)
            ppu_pkg::REG_STATUS: begin
               rd_data     = status_ff;
               status_in   = status_ff & ppu_pkg::STATUS_KEEP;
               scroll_t_in = 1'b0;
               addr_t_in   = 1'b0;
            end
            ppu_pkg::REG_DATA: begin
               rd_data        = buffer_data;
               vram_req.rd_en = 1'b1;
               vaddr_in       = vaddr_ff + step;
            end
            default: begin
            end
         endcase
      end else if (accept && (func == ppu_pkg::FUNC_STATUS)) begin
         status_in = write_data;
      end
   end

   // Result of the transfer, taken from the updated state
   always_comb begin
      result.read_data       = rd_data;
      result.current_address = vaddr_in;
      result.temp_address    = latch_in;
      result.fine_scroll_x   = fine_x_in;
      result.control0        = ctrl0_in;
      result.control1        = ctrl1_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl0_ff    <= '0;
         ctrl1_ff    <= '0;
         status_ff   <= '0;
         latch_ff    <= '0;
         vaddr_ff    <= '0;
         fine_x_ff   <= '0;
         scroll_t_ff <= 1'b0;
         addr_t_ff   <= 1'b0;
      end else begin
         ctrl0_ff    <= ctrl0_in;
         ctrl1_ff    <= ctrl1_in;
         status_ff   <= status_in;
         latch_ff    <= latch_in;
         vaddr_ff    <= vaddr_in;
         fine_x_ff   <= fine_x_in;
         scroll_t_ff <= scroll_t_in;
         addr_t_ff   <= addr_t_in;
      end
   end

endmodule

`default_nettype wire

[rtl/ppu_rsp_skid.sv]
`default_nettype none

// Result register with a skid entry behind it
module ppu_rsp_skid (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                in_transfer,
   input  wire ppu_pkg::result_type in_data,
   output logic                     in_ready,
   output logic                     out_valid,
   input  wire logic                out_ready,
   output ppu_pkg::result_type      out_data
);

   logic                out_valid_ff;
   logic                skid_valid_ff;
   ppu_pkg::result_type out_data_ff;
   ppu_pkg::result_type skid_data_ff;
   logic                out_free;

   assign in_ready  = ~skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;
   assign out_free  = ~out_valid_ff | out_ready;

   // Control
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff  <= skid_valid_ff | in_transfer;
         skid_valid_ff <= 1'b0;
      end else if (in_transfer) begin
         skid_valid_ff <= 1'b1;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      if (out_free) begin
         out_data_ff <= skid_valid_ff ? skid_data_ff : in_data;
      end
      if (!out_free && in_transfer) begin
         skid_data_ff <= in_data;
      end
   end

endmodule

`default_nettype wire

[sim/ppu_cpu_register_port_tb.sv]
`timescale 1ns / 1ps

module ppu_cpu_register_port_tb;
   import ppu_pkg::*;

   localparam int unsigned VRAM_DEPTH      = 1 << VADDR_W;
   localparam int unsigned RANDOM_ACCESSES = 650;
   localparam int unsigned PHASES          = 4;

   // One CPU bus access
   typedef struct packed {
      logic [1:0] func;
      logic [2:0] reg_index;
      logic [7:0] write_data;
   } bus_access_t;

   // Register side of the port, plus the byte returned by the last access
   typedef struct packed {
      logic [7:0]  ctrl0, ctrl1, status, spr_addr, rd_buf, rd_out;
      logic [14:0] latch;
      logic [15:0] vaddr;
      logic [2:0]  fine_x;
      logic        scroll_tog, addr_tog;
   } port_regs_t;

   logic clock = 1'b0;
   logic reset = 1'b1;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   ppu_req_if req_bus();
   ppu_rsp_if rsp_bus();

   ppu_cpu_register_port dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   bus_access_t drv_access = '0;
   logic        drv_valid  = 1'b0;
   logic        sink_ready = 1'b0;
   logic        req_fired  = 1'b0;

   assign req_bus.valid      = drv_valid;
   assign req_bus.func       = drv_access.func;
   assign req_bus.reg_index  = drv_access.reg_index;
   assign req_bus.write_data = drv_access.write_data;
   assign rsp_bus.ready      = sink_ready;

   bus_access_t bus_accesses[$];
   result_type  awaited_results[$];

   // Generator-side copy: tracks the address so data-port reads only hit written bytes
   port_regs_t plan_regs = '0;
   bit         plan_written [VRAM_DEPTH];

   // Checker-side copy, advanced on each accepted transfer
   port_regs_t model_regs = '0;
   logic [7:0] model_vram [VRAM_DEPTH];

   int unsigned idle_pct     = 0;
   int unsigned stall_pct    = 0;
   int unsigned counted      = 0;
   int unsigned accepted     = 0;
   int unsigned results_seen = 0;
   int unsigned data_reads   = 0;
   int unsigned failures     = 0;

   // Register update for one access; vbyte is video memory at the old address
   function automatic port_regs_t next_port_state(port_regs_t s, bus_access_t a,
                                                  logic [7:0] vbyte);
      port_regs_t  n;
      logic [15:0] step;
      logic [7:0]  d;
      n = s;
      n.rd_out = 8'h00;
      d = a.write_data;
      step = s.ctrl0[STEP_BIT] ? STEP_ROW : STEP_ONE;
      case (a.func)
         FUNC_WRITE: begin
            case (a.reg_index)
               REG_CTRL0: begin
                  n.ctrl0 = d;
                  n.latch[11:10] = d[1:0];
               end
               REG_CTRL1:   n.ctrl1 = d;
               REG_SPR_ADR: n.spr_addr = d;
               REG_SPR_DAT: n.spr_addr = s.spr_addr + 8'd1;
               REG_SCROLL: begin
                  if (s.scroll_tog) begin
                     n.latch[9:5]   = d[7:3];
                     n.latch[14:12] = d[2:0];
                  end else begin
                     n.latch[4:0] = d[7:3];
                     n.fine_x     = d[2:0];
                  end
                  n.scroll_tog = ~s.scroll_tog;
               end
               REG_ADDRESS: begin
                  if (s.addr_tog) begin
                     n.latch[7:0] = d;
                     n.vaddr      = {1'b0, n.latch};
                  end else begin
                     n.latch[14:8] = {1'b0, d[5:0]};
                  end
                  n.addr_tog = ~s.addr_tog;
               end
               REG_DATA: n.vaddr = s.vaddr + step;
               default: ;
            endcase
         end
         FUNC_READ: begin
            if (a.reg_index == REG_STATUS) begin
               n.rd_out     = s.status;
               n.status     = s.status & STATUS_KEEP;
               n.scroll_tog = 1'b0;
               n.addr_tog   = 1'b0;
            end else if (a.reg_index == REG_DATA) begin
               n.rd_out = s.rd_buf;
               n.rd_buf = vbyte;
               n.vaddr  = s.vaddr + step;
            end
         end
         FUNC_STATUS: n.status = d;
         default: ;
      endcase
      return n;
   endfunction

   // Second location written by a data-port write in the mirrored window; bit 14 flags it
   function automatic logic [14:0] vram_alias(logic [VADDR_W-1:0] a);
      if (a >= MIRROR_LO && a <= MIRROR_HI)
         return {1'b1, a - MIRROR_LO + NT_LO};
      return 15'h0;
   endfunction

   task automatic note_failure(string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      failures++;
   endtask

   // Queue one access; a data-port read of an unwritten byte becomes a write there
   task automatic plan_access(logic [1:0] f, logic [2:0] r, logic [7:0] d);
      bus_access_t a;
      logic [14:0] al;
      a.func       = f;
      a.reg_index  = r;
      a.write_data = d;
      if (f == FUNC_READ && r == REG_DATA && !plan_written[plan_regs.vaddr[VADDR_W-1:0]])
         a.func = FUNC_WRITE;
      if (a.func == FUNC_WRITE && a.reg_index == REG_DATA) begin
         plan_written[plan_regs.vaddr[VADDR_W-1:0]] = 1'b1;
         al = vram_alias(plan_regs.vaddr[VADDR_W-1:0]);
         if (al[14])
            plan_written[al[13:0]] = 1'b1;
      end
      plan_regs = next_port_state(plan_regs, a, 8'h00);
      bus_accesses.push_back(a);
      // status writes, unused funcs and reads without a read path are not counted
      if (!(a.func == FUNC_NONE ||
            (a.func == FUNC_WRITE && a.reg_index == REG_STATUS) ||
            (a.func == FUNC_READ && a.reg_index != REG_STATUS && a.reg_index != REG_DATA)))
         counted++;
   endtask

   // Load the video address; optionally route bits 12..14 through the scroll register
   task automatic aim_address(logic [7:0] hi, logic [7:0] lo, bit via_scroll);
      plan_access(FUNC_WRITE, REG_ADDRESS, hi);
      if (via_scroll) begin
         plan_access(FUNC_WRITE, REG_SCROLL, 8'($urandom));
         plan_access(FUNC_WRITE, REG_SCROLL, {5'($urandom), 1'($urandom), hi[5:4]});
      end
      plan_access(FUNC_WRITE, REG_ADDRESS, lo);
   endtask

   // One random sequence: a data round trip through the video memory in four of ten draws
   task automatic random_sequence();
      logic [7:0]  d, hi, lo, rd_hi;
      int unsigned len;
      bit          via_scroll;
      d = 8'($urandom);
      case ($urandom_range(9))
         0, 1, 2, 3: begin
            case ($urandom_range(3))
               0: hi = 8'h3F;
               1: hi = 8'h30 + 8'($urandom_range(14));
               2: hi = 8'h20 + 8'($urandom_range(15));
               default: hi = d;
            endcase
            hi[7:6]    = 2'($urandom);
            lo         = 8'($urandom);
            len        = $urandom_range(8, 1);
            via_scroll = ($urandom_range(3) == 0);
            if ($urandom_range(2) == 0)
               plan_access(FUNC_WRITE, REG_CTRL0, 8'($urandom));
            plan_access(FUNC_READ, REG_STATUS, 8'($urandom));
            aim_address(hi, lo, via_scroll);
            repeat (len) plan_access(FUNC_WRITE, REG_DATA, 8'($urandom));
            // read back either directly or through the lower mirror copy
            rd_hi = hi;
            if (hi[5:4] == 2'b11 && hi[5:0] != 6'h3F && $urandom_range(1) == 1)
               rd_hi = hi - 8'h10;
            plan_access(FUNC_READ, REG_STATUS, 8'($urandom));
            aim_address(rd_hi, lo, via_scroll);
            repeat (len) plan_access(FUNC_READ, REG_DATA, 8'($urandom));
         end
         4: plan_access(FUNC_WRITE, ($urandom_range(1) == 1) ? REG_CTRL1 : REG_CTRL0, d);
         5: begin
            plan_access(FUNC_WRITE, REG_SCROLL, d);
            plan_access(FUNC_WRITE, REG_SCROLL, 8'($urandom));
         end
         6: begin
            plan_access(FUNC_WRITE, REG_SPR_ADR, d);
            repeat ($urandom_range(4, 1)) plan_access(FUNC_WRITE, REG_SPR_DAT, 8'($urandom));
         end
         7: begin
            plan_access(FUNC_STATUS, 3'($urandom), d);
            plan_access(FUNC_READ, REG_STATUS, 8'($urandom));
         end
         8: begin
            case ($urandom_range(2))
               0: plan_access(FUNC_WRITE, REG_STATUS, d);
               1: plan_access(FUNC_NONE, 3'($urandom), d);
               default: plan_access(FUNC_READ, 3'($urandom), d);
            endcase
         end
         default: plan_access(2'($urandom), 3'($urandom), d);
      endcase
   endtask

   // Request driver: next access offered at the falling edge
   always @(negedge clock) begin
      if (reset) begin
         drv_valid <= 1'b0;
      end else if (!drv_valid || req_fired) begin
         if (bus_accesses.size() != 0 && $urandom_range(99) >= idle_pct) begin
            drv_access <= bus_accesses.pop_front();
            drv_valid  <= 1'b1;
         end else begin
            drv_valid <= 1'b0;
         end
      end
   end

   // Result sink stalls
   always @(negedge clock) begin
      sink_ready <= !reset && ($urandom_range(99) >= stall_pct);
   end

   // Monitor: predict on each request transfer, check each result transfer
   always @(posedge clock) begin
      bus_access_t acc;
      result_type  want;
      logic [7:0]  vbyte;
      logic [14:0] al;
      req_fired <= !reset && req_bus.valid && req_bus.ready;
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            acc   = {req_bus.func, req_bus.reg_index, req_bus.write_data};
            vbyte = model_vram[model_regs.vaddr[VADDR_W-1:0]];
            if (acc.func == FUNC_WRITE && acc.reg_index == REG_DATA) begin
               model_vram[model_regs.vaddr[VADDR_W-1:0]] = acc.write_data;
               al = vram_alias(model_regs.vaddr[VADDR_W-1:0]);
               if (al[14])
                  model_vram[al[13:0]] = acc.write_data;
            end
            if (acc.func == FUNC_READ && acc.reg_index == REG_DATA)
               data_reads++;
            model_regs = next_port_state(model_regs, acc, vbyte);
            want.read_data       = model_regs.rd_out;
            want.current_address = model_regs.vaddr;
            want.temp_address    = model_regs.latch;
            want.fine_scroll_x   = model_regs.fine_x;
            want.control0        = model_regs.ctrl0;
            want.control1        = model_regs.ctrl1;
            awaited_results.push_back(want);
            accepted++;
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            results_seen++;
            if (awaited_results.size() == 0) begin
               note_failure("result transfer with nothing outstanding");
            end else begin
               want = awaited_results.pop_front();
               if (rsp_bus.read_data !== want.read_data)
                  note_failure($sformatf("read_data %h, want %h",
                                         rsp_bus.read_data, want.read_data));
               if (rsp_bus.current_address !== want.current_address)
                  note_failure($sformatf("current_address %h, want %h",
                                         rsp_bus.current_address, want.current_address));
               if (rsp_bus.temp_address !== want.temp_address)
                  note_failure($sformatf("temp_address %h, want %h",
                                         rsp_bus.temp_address, want.temp_address));
               if (rsp_bus.fine_scroll_x !== want.fine_scroll_x)
                  note_failure($sformatf("fine_scroll_x %h, want %h",
                                         rsp_bus.fine_scroll_x, want.fine_scroll_x));
               if (rsp_bus.control0 !== want.control0)
                  note_failure($sformatf("control0 %h, want %h",
                                         rsp_bus.control0, want.control0));
               if (rsp_bus.control1 !== want.control1)
                  note_failure($sformatf("control1 %h, want %h",
                                         rsp_bus.control1, want.control1));
            end
         end
      end
   end

   // Main sequence
   initial begin
      int unsigned phase;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 73; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 73; end
            default: begin idle_pct = 21; stall_pct = 21; end
         endcase
         if (phase == 0) begin
            // control extremes, step of 32 selected
            plan_access(FUNC_WRITE, REG_CTRL0, 8'hFF);
            plan_access(FUNC_WRITE, REG_CTRL1, 8'hFF);
            // status load, read clears the top three bits
            plan_access(FUNC_STATUS, REG_CTRL0, 8'hFF);
            plan_access(FUNC_READ, REG_STATUS, 8'h00);
            plan_access(FUNC_READ, REG_STATUS, 8'hFF);
            // ignored: status write, unused func, read of a write-only register
            plan_access(FUNC_WRITE, REG_STATUS, 8'hAA);
            plan_access(FUNC_NONE, REG_DATA, 8'h55);
            plan_access(FUNC_READ, REG_CTRL0, 8'h00);
            // both scroll writes with all ones
            plan_access(FUNC_WRITE, REG_SCROLL, 8'hFF);
            plan_access(FUNC_WRITE, REG_SCROLL, 8'hFF);
            plan_access(FUNC_WRITE, REG_CTRL0, 8'h00);
            plan_access(FUNC_WRITE, REG_CTRL1, 8'h00);
            // palette window
            plan_access(FUNC_WRITE, REG_ADDRESS, 8'hFF);
            plan_access(FUNC_WRITE, REG_ADDRESS, 8'h00);
            plan_access(FUNC_WRITE, REG_DATA, 8'hFF);
            plan_access(FUNC_WRITE, REG_DATA, 8'h00);
            // mirrored write at 0x3000, read back at 0x2000 through the buffer
            plan_access(FUNC_WRITE, REG_ADDRESS, 8'h30);
            plan_access(FUNC_WRITE, REG_ADDRESS, 8'h00);
            plan_access(FUNC_WRITE, REG_DATA, 8'hA5);
            plan_access(FUNC_WRITE, REG_DATA, 8'h5A);
            plan_access(FUNC_WRITE, REG_ADDRESS, 8'h20);
            plan_access(FUNC_WRITE, REG_ADDRESS, 8'h00);
            plan_access(FUNC_READ, REG_DATA, 8'h00);
            plan_access(FUNC_READ, REG_DATA, 8'h00);
            // sprite address wraps
            plan_access(FUNC_WRITE, REG_SPR_ADR, 8'hFF);
            plan_access(FUNC_WRITE, REG_SPR_DAT, 8'h12);
            // video address above 0x3FFF via the scroll bits
            plan_access(FUNC_READ, REG_STATUS, 8'h00);
            plan_access(FUNC_WRITE, REG_ADDRESS, 8'h00);
            plan_access(FUNC_WRITE, REG_SCROLL, 8'h00);
            plan_access(FUNC_WRITE, REG_SCROLL, 8'h07);
            plan_access(FUNC_WRITE, REG_ADDRESS, 8'hFF);
            plan_access(FUNC_WRITE, REG_DATA, 8'h3C);
            counted = 0;
         end
         while (counted < (phase + 1) * RANDOM_ACCESSES / PHASES)
            random_sequence();
         while (bus_accesses.size() != 0 || drv_valid || awaited_results.size() != 0)
            @(negedge clock);
      end

      // settle: nothing further may arrive
      repeat (8) @(posedge clock);
      if (awaited_results.size() != 0)
         note_failure($sformatf("%0d results never arrived", awaited_results.size()));

      $display("Covered %0d register accesses over four pacing phases (free, sender gaps,",
               accepted);
      $display("sink stalls, both); %0d results compared, %0d data-port reads.",
               results_seen, data_reads);
      if (failures == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

   // Watchdog
   initial begin
      #2_000_000;
      $display("simulation failed");
      $finish;
   end

endmodule
